FILE: rtl/sqsweep_pkg.sv
// Shared types, constants and helpers for the square channel with sweep and envelope.
// No dependencies; the frame, core and top files refer to this package by scoped names.
package sqsweep_pkg;

   localparam int FRAME_PERIOD = 2048;
   localparam int FRAME_CNT_W  = $clog2(FRAME_PERIOD + 1);

   localparam int PERIOD_W = 11;
   localparam int FREQ_W   = 12;
   localparam int LEN_W    = 7;

   localparam logic [FREQ_W-1:0]   FREQ_BASE = 12'd2048;
   localparam logic [LEN_W-1:0]    LEN_FULL  = 7'd64;

   // Register indexes of a write beat.
   localparam logic [2:0] REG_SWEEP  = 3'd0;
   localparam logic [2:0] REG_DUTY   = 3'd1;
   localparam logic [2:0] REG_ENV    = 3'd2;
   localparam logic [2:0] REG_FREQ_L = 3'd3;
   localparam logic [2:0] REG_FREQ_H = 3'd4;
   localparam logic [2:0] REG_POWER  = 3'd5;

   // Beat modes.
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   // Frame sequencer strobes for the current tick.
   typedef struct packed {
      logic length_clk;
      logic sweep_clk;
      logic env_clk;
   } frame_strobe_type;

   // Value of the channel outputs after the current beat.
   typedef struct packed {
      logic [3:0] level;
      logic       channel_on;
   } chan_out_type;

   function automatic logic [7:0] duty_lookup(input logic [1:0] sel);
      logic [7:0] pat;
      unique case (sel)
         2'd0: pat = 8'b0000_0001;
         2'd1: pat = 8'b1000_0001;
         2'd2: pat = 8'b1000_0111;
         2'd3: pat = 8'b0111_1110;
         default: pat = 8'b0000_0001;
      endcase
      return pat;
   endfunction

endpackage

FILE: rtl/sqsweep_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on nothing; the payload widths are fixed by the channel definition.
interface sqsweep_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [2:0] reg_index;
   logic [7:0] write_data;

   modport source (output valid, output mode, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input mode, input reg_index, input write_data,
                   output ready);
endinterface

interface sqsweep_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] level;
   logic       channel_on;

   modport source (output valid, output level, output channel_on, input ready);
   modport sink   (input valid, input level, input channel_on, output ready);
endinterface

FILE: rtl/sqsweep_frame.sv
// Eight-step frame sequencer that strobes the length, sweep and envelope units.
// Depends on sqsweep_pkg.
module sqsweep_frame (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   output sqsweep_pkg::frame_strobe_type strobe
);

   logic [sqsweep_pkg::FRAME_CNT_W-1:0] frame_count_ff, frame_count_in;
   logic [2:0]                          frame_step_ff, frame_step_in;
   logic                                step_due;

   always_comb begin
      step_due       = tick && (frame_count_ff <= sqsweep_pkg::FRAME_CNT_W'(1));
      frame_count_in = frame_count_ff;
      frame_step_in  = frame_step_ff;
      if (tick) begin
         if (step_due) begin
            frame_count_in = sqsweep_pkg::FRAME_CNT_W'(sqsweep_pkg::FRAME_PERIOD);
            frame_step_in  = frame_step_ff + 3'd1;
         end else begin
            frame_count_in = frame_count_ff - sqsweep_pkg::FRAME_CNT_W'(1);
         end
      end
      // Length on even steps, sweep on steps 2 and 6, envelope on step 7.
      strobe.length_clk = step_due && !frame_step_ff[0];
      strobe.sweep_clk  = step_due && (frame_step_ff == 3'd2 || frame_step_ff == 3'd6);
      strobe.env_clk    = step_due && (frame_step_ff == 3'd7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= sqsweep_pkg::FRAME_CNT_W'(sqsweep_pkg::FRAME_PERIOD);
         frame_step_ff  <= 3'd0;
      end else begin
         frame_count_ff <= frame_count_in;
         frame_step_ff  <= frame_step_in;
      end
   end

endmodule

FILE: rtl/sqsweep_core.sv
// Channel state: frequency timer, duty pattern, length, sweep, envelope and register writes.
// Depends on sqsweep_pkg; frame strobes come from sqsweep_frame.
module sqsweep_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          mode,
   input  logic [2:0]                    reg_index,
   input  logic [7:0]                    write_data,
   input  sqsweep_pkg::frame_strobe_type strobe,
   output sqsweep_pkg::chan_out_type     next_out
);

   localparam int PW = sqsweep_pkg::PERIOD_W;
   localparam int FW = sqsweep_pkg::FREQ_W;
   localparam int LW = sqsweep_pkg::LEN_W;

   logic          powered_ff, powered_in;
   logic          enabled_ff, enabled_in;
   logic [7:0]    duty_ff, duty_in;
   logic [PW-1:0] period_ff, period_in;
   logic [FW-1:0] freq_ff, freq_in;
   logic          running_ff, running_in;
   logic [LW-1:0] length_ff, length_in;
   logic [2:0]    sw_amount_ff, sw_amount_in;
   logic          sw_down_ff, sw_down_in;
   logic [2:0]    sw_count_ff, sw_count_in;
   logic [3:0]    volume_ff, volume_in;
   logic          env_up_ff, env_up_in;
   logic [2:0]    env_count_ff, env_count_in;
   logic [3:0]    amp_ff, amp_in;

   logic          tick;
   logic [LW-1:0] length_dec;
   logic [2:0]    sw_count_dec;
   logic [2:0]    env_count_dec;
   logic [PW-1:0] sw_delta;
   logic [FW-1:0] sw_next;
   logic [PW-1:0] period_wr;

   always_comb begin
      powered_in   = powered_ff;
      enabled_in   = enabled_ff;
      duty_in      = duty_ff;
      period_in    = period_ff;
      freq_in      = freq_ff;
      running_in   = running_ff;
      length_in    = length_ff;
      sw_amount_in = sw_amount_ff;
      sw_down_in   = sw_down_ff;
      sw_count_in  = sw_count_ff;
      volume_in    = volume_ff;
      env_up_in    = env_up_ff;
      env_count_in = env_count_ff;
      amp_in       = amp_ff;

      tick          = accept && (mode == sqsweep_pkg::MODE_TICK);
      length_dec    = (length_ff != '0) ? length_ff - LW'(1) : '0;
      sw_count_dec  = (sw_count_ff != '0) ? sw_count_ff - 3'd1 : '0;
      env_count_dec = (env_count_ff != '0) ? env_count_ff - 3'd1 : '0;
      sw_delta      = period_ff >> sw_amount_ff;
      sw_next       = sw_down_ff ? ({1'b0, period_ff} - {1'b0, sw_delta})
                                 : ({1'b0, period_ff} + {1'b0, sw_delta});
      period_wr     = period_ff;

      if (tick) begin
         // The frequency timer goes first; the sweep may then restart it.
         if (running_ff) begin
            if (freq_ff <= FW'(1)) begin
               freq_in = sqsweep_pkg::FREQ_BASE - {1'b0, period_ff};
               if (!enabled_ff) begin
                  amp_in = 4'd0;
               end else begin
                  amp_in  = duty_ff[0] ? volume_ff : 4'd0;
                  duty_in = {duty_ff[0], duty_ff[7:1]};
               end
            end else begin
               freq_in = freq_ff - FW'(1);
            end
         end
         if (strobe.length_clk) begin
            length_in = length_dec;
            if (length_dec == '0) begin
               enabled_in = 1'b0;
            end
         end
         if (strobe.sweep_clk) begin
            sw_count_in = sw_count_dec;
            if (sw_count_dec == '0) begin
               if (sw_next[FW-1]) begin
                  enabled_in = 1'b0;
               end else begin
                  period_in  = sw_next[PW-1:0];
                  freq_in    = sqsweep_pkg::FREQ_BASE - sw_next;
                  running_in = 1'b1;
               end
            end
         end
         if (strobe.env_clk) begin
            env_count_in = env_count_dec;
            if (env_count_dec == '0) begin
               if (env_up_ff) begin
                  if (volume_ff != 4'hF) begin
                     volume_in = volume_ff + 4'd1;
                  end
               end else begin
                  if (volume_ff != 4'h0) begin
                     volume_in = volume_ff - 4'd1;
                  end
               end
            end
         end
      end else if (accept) begin
         if (reg_index == sqsweep_pkg::REG_POWER) begin
            powered_in = write_data[7];
            enabled_in = 1'b0;
         end else if (powered_ff) begin
            unique case (reg_index)
               sqsweep_pkg::REG_SWEEP: begin
                  sw_amount_in = write_data[2:0];
                  sw_down_in   = write_data[3];
                  sw_count_in  = write_data[6:4];
               end
               sqsweep_pkg::REG_DUTY: begin
                  duty_in   = sqsweep_pkg::duty_lookup(write_data[7:6]);
                  length_in = sqsweep_pkg::LEN_FULL - {1'b0, write_data[5:0]};
               end
               sqsweep_pkg::REG_ENV: begin
                  volume_in    = write_data[7:4];
                  env_up_in    = write_data[3];
                  env_count_in = write_data[2:0];
               end
               sqsweep_pkg::REG_FREQ_L: begin
                  period_in = {period_ff[PW-1:8], write_data};
               end
               sqsweep_pkg::REG_FREQ_H: begin
                  period_wr = {write_data[2:0], period_ff[7:0]};
                  period_in = period_wr;
                  if (write_data[7]) begin
                     freq_in    = sqsweep_pkg::FREQ_BASE - {1'b0, period_wr};
                     running_in = 1'b1;
                     enabled_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      next_out.level      = amp_in;
      next_out.channel_on = enabled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         powered_ff   <= 1'b0;
         enabled_ff   <= 1'b0;
         duty_ff      <= '0;
         period_ff    <= '0;
         freq_ff      <= '0;
         running_ff   <= 1'b0;
         length_ff    <= '0;
         sw_amount_ff <= '0;
         sw_down_ff   <= 1'b0;
         sw_count_ff  <= '0;
         volume_ff    <= '0;
         env_up_ff    <= 1'b0;
         env_count_ff <= '0;
         amp_ff       <= '0;
      end else begin
         powered_ff   <= powered_in;
         enabled_ff   <= enabled_in;
         duty_ff      <= duty_in;
         period_ff    <= period_in;
         freq_ff      <= freq_in;
         running_ff   <= running_in;
         length_ff    <= length_in;
         sw_amount_ff <= sw_amount_in;
         sw_down_ff   <= sw_down_in;
         sw_count_ff  <= sw_count_in;
         volume_ff    <= volume_in;
         env_up_ff    <= env_up_in;
         env_count_ff <= env_count_in;
         amp_ff       <= amp_in;
      end
   end

endmodule

FILE: rtl/square_channel_sweep_envelope_top.sv
// Top level of the square channel with sweep, length counter and volume envelope.
// Depends on sqsweep_pkg, sqsweep_if, sqsweep_frame and sqsweep_core.
//
//   Channel   Direction  Beat contents
//   req_if    in         mode, reg_index, write_data (one tick or one register write)
//   rsp_if    out        level, channel_on (channel state after that beat)
//
// Every accepted request beat yields exactly one response beat. The channel state is
// updated at the edge that accepts the beat, and the result is held in an output
// register: one beat is taken per cycle unless stalled, and answered in the next cycle.
// A stalled response holds the output register and drops req_if.ready only while the
// register is full and not being taken; reset clears all control and channel state and
// loads the frame sequencer with a full frame period.
module square_channel_sweep_envelope_top (
   input  logic                 clock,
   input  logic                 reset,
   sqsweep_req_if.sink          req_if,
   sqsweep_rsp_if.source        rsp_if
);

   logic                             accept;
   sqsweep_pkg::frame_strobe_type    strobe;
   sqsweep_pkg::chan_out_type        next_out;
   logic                             rsp_valid_ff, rsp_valid_in;
   sqsweep_pkg::chan_out_type        rsp_data_ff, rsp_data_in;

   // The output register can take a new beat when empty or when being drained.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   sqsweep_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .tick   (accept && (req_if.mode == sqsweep_pkg::MODE_TICK)),
      .strobe (strobe)
   );

   sqsweep_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_if.mode),
      .reg_index  (req_if.reg_index),
      .write_data (req_if.write_data),
      .strobe     (strobe),
      .next_out   (next_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = next_out;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload needs no reset; it is only looked at while valid is high.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.level      = rsp_data_ff.level;
   assign rsp_if.channel_on = rsp_data_ff.channel_on;

endmodule
